[design/rlgp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the run-length gcd padding block.
// Depends on nothing; used by rlgp_gcd and run_length_gcd_padding.
package rlgp_pkg;

    localparam int COEF_W     = 64;
    localparam int LEN_W      = 13;
    localparam int MAX_COEFFS = 4096;
    localparam int LEN_CAP    = (MAX_COEFFS < 8191) ? MAX_COEFFS : 8191;
    localparam int SHIFT_W    = $clog2(LEN_W);

    typedef struct packed {
        logic             go;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
    } gcd_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] value;
    } gcd_rsp_t;

endpackage

[design/run_length_gcd_padding.sv]
`timescale 1ns / 1ps
// Padding width of a lookup-table polynomial: gcd of the lengths of equal-coefficient runs.
// An item that neither ends a run nor is last keeps busy high through the update and check
// states. Each gcd (at a run end, and again on the last item) runs on the shared binary
// gcd unit, which does one compare, subtract or halving step at a time.
// The width appears on pad_width with done high for one cycle. Reset clears the control
// state, not the held coefficient, last flag or width. Depends on rlgp_pkg and rlgp_gcd.
module run_length_gcd_padding
    import rlgp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [COEF_W-1:0] coefficient,
    input  logic              is_last,
    output logic              done,
    output logic [LEN_W-1:0]  pad_width
);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_UPDATE    = 5'b00010,
        ST_RUN_WAIT  = 5'b00100,
        ST_CHECK     = 5'b01000,
        ST_LAST_WAIT = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    logic              last_reg, last_next;
    logic [COEF_W-1:0] prev_reg, prev_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  div_reg, div_next;
    logic              have_reg, have_next;
    logic              done_reg, done_next;
    logic [LEN_W-1:0]  width_reg, width_next;
    gcd_req_t          gcd_req;
    gcd_rsp_t          gcd_rsp;

    rlgp_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (gcd_req),
        .rsp   (gcd_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        coef_next  = coef_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        div_next   = div_reg;
        have_next  = have_reg;
        done_next  = 1'b0;
        width_next = width_reg;
        gcd_req.go = 1'b0;
        gcd_req.a  = div_reg;
        gcd_req.b  = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    coef_next  = coefficient;
                    last_next  = is_last;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!have_reg)
                begin
                    have_next  = 1'b1;
                    prev_next  = coef_reg;
                    len_next   = LEN_W'(1);
                    state_next = ST_CHECK;
                end
                else if (coef_reg == prev_reg)
                begin
                    // Run lengths saturate at the cap.
                    if (len_reg < LEN_W'(LEN_CAP))
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    state_next = ST_CHECK;
                end
                else
                begin
                    gcd_req.go = 1'b1;
                    state_next = ST_RUN_WAIT;
                end
            end
            ST_RUN_WAIT:
            begin
                if (gcd_rsp.done)
                begin
                    div_next   = gcd_rsp.value;
                    prev_next  = coef_reg;
                    len_next   = LEN_W'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (last_reg)
                begin
                    gcd_req.go = 1'b1;
                    state_next = ST_LAST_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LAST_WAIT:
            begin
                if (gcd_rsp.done)
                begin
                    width_next = gcd_rsp.value;
                    done_next  = 1'b1;
                    prev_next  = '0;
                    len_next   = '0;
                    div_next   = '0;
                    have_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg  <= '0;
            len_reg   <= '0;
            div_reg   <= '0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            div_reg   <= div_next;
            have_reg  <= have_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg  <= coef_next;
        last_reg  <= last_next;
        width_reg <= width_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign pad_width = width_reg;

    // A width is only ever produced by the final gcd of a polynomial.
    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LAST_WAIT))
        else $error("done without a final gcd");

    // Every polynomial has at least one run, so the width is never zero.
    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pad_width != '0))
        else $error("zero padding width");

    // The run length never passes the cap and is nonzero once a coefficient is held.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LEN_W'(LEN_CAP)) && (!have_reg || (len_reg != '0)))
        else $error("run length out of range");

    // An accepted item makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

endmodule

[design/rlgp_gcd.sv]
`timescale 1ns / 1ps
// Iterative binary gcd over run lengths: one compare, subtract or shift per cycle.
// Depends on rlgp_pkg.
module rlgp_gcd
    import rlgp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gcd_req_t req,
    output gcd_rsp_t rsp
);

    typedef enum logic [1:0] {
        G_IDLE = 2'b01,
        G_RUN  = 2'b10
    } gcd_state_t;

    gcd_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   a_reg, a_next;
    logic [LEN_W-1:0]   b_reg, b_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic               done_reg, done_next;
    logic [LEN_W-1:0]   value_reg, value_next;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        unique case (state_reg)
            G_IDLE:
            begin
                if (req.go)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    k_next     = '0;
                    state_next = G_RUN;
                end
            end
            G_RUN:
            begin
                // gcd(0, x) = x; the common factor of two is restored at the end.
                priority if (a_reg == '0)
                begin
                    value_next = LEN_W'(b_reg << k_reg);
                    done_next  = 1'b1;
                    state_next = G_IDLE;
                end
                else if (b_reg == '0)
                begin
                    value_next = LEN_W'(a_reg << k_reg);
                    done_next  = 1'b1;
                    state_next = G_IDLE;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + SHIFT_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_next = a_reg - b_reg;
                end
                else
                begin
                    b_next = b_reg - a_reg;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for run_length_gcd_padding: polynomials of coefficient runs go in,
// and each padding width is checked against an in-bench run-length gcd predictor.
// Depends on rlgp_pkg and the run_length_gcd_padding RTL.
module testbench;
    import rlgp_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_ITEMS  = 1950;

    typedef struct {
        logic [COEF_W-1:0] coef;
        logic              is_end;
        int                idle_pct;
    } coef_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start = 1'b0;
    logic              busy;
    logic [COEF_W-1:0] coefficient = '0;
    logic              is_last = 1'b0;
    logic              done;
    logic [LEN_W-1:0]  pad_width;

    coef_item_t        pending_coefs[$];
    logic [LEN_W-1:0]  widths_due[$];
    int                phase_idle_pct;
    int                error_count = 0;
    int                cycle_count = 0;
    logic              took_item = 1'b0;

    // Predictor state for the polynomial in progress.
    logic [COEF_W-1:0] pred_prev_coef = '0;
    logic [LEN_W-1:0]  pred_run_len = '0;
    logic [LEN_W-1:0]  pred_divisor = '0;
    logic              pred_have_prev = 1'b0;

    run_length_gcd_padding u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .coefficient (coefficient),
        .is_last     (is_last),
        .done        (done),
        .pad_width   (pad_width)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [LEN_W-1:0] lengths_gcd(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W-1:0] x;
        logic [LEN_W-1:0] y;
        logic [LEN_W-1:0] r;
        x = a;
        y = b;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic predict_width(input logic [COEF_W-1:0] coef, input logic is_end);
        if (!pred_have_prev)
        begin
            pred_have_prev = 1'b1;
            pred_prev_coef = coef;
            pred_run_len   = LEN_W'(1);
        end
        else if (coef == pred_prev_coef)
        begin
            if (pred_run_len < LEN_CAP)
                pred_run_len = pred_run_len + 1'b1;
        end
        else
        begin
            pred_divisor   = lengths_gcd(pred_divisor, pred_run_len);
            pred_prev_coef = coef;
            pred_run_len   = LEN_W'(1);
        end
        if (is_end)
        begin
            widths_due.push_back(lengths_gcd(pred_divisor, pred_run_len));
            pred_prev_coef = '0;
            pred_run_len   = '0;
            pred_divisor   = '0;
            pred_have_prev = 1'b0;
        end
    endtask

    task automatic queue_coef(input logic [COEF_W-1:0] coef, input logic is_end);
        coef_item_t item;
        item.coef     = coef;
        item.is_end   = is_end;
        item.idle_pct = phase_idle_pct;
        pending_coefs.push_back(item);
    endtask

    // Queues a run of equal coefficients; the polynomial ends on its last one if asked.
    task automatic queue_run(input logic [COEF_W-1:0] value, input int len, input logic ends);
        for (int i = 0; i < len; i++)
            queue_coef(value, ends && (i == len - 1));
    endtask

    function automatic logic [COEF_W-1:0] pick_value();
        logic [COEF_W-1:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = {{(COEF_W-1){1'b0}}, 1'b1} << $urandom_range(COEF_W - 1);
            3: v = COEF_W'($urandom_range(3));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Builds one random polynomial and returns how many items it took.
    task automatic queue_polynomial(output int n_items);
        int                n_runs;
        int                base;
        int                mode;
        int                len;
        logic [COEF_W-1:0] value;
        logic [COEF_W-1:0] prev_value;
        n_items    = 0;
        n_runs     = $urandom_range(1, 6);
        base       = $urandom_range(1, 6);
        mode       = $urandom_range(9);
        prev_value = pick_value();
        for (int r = 0; r < n_runs; r++)
        begin
            if (mode < 5)
                len = base * $urandom_range(1, 4);
            else if (mode < 7)
                len = $urandom_range(1, 12);
            else if (mode == 9)
                len = $urandom_range(1, 40);
            else
                len = $urandom_range(1, 5);
            if (mode == 7)
            begin
                // Noise: coefficients drawn from a tiny set, so runs form by chance.
                for (int i = 0; i < len; i++)
                    queue_coef(COEF_W'($urandom_range(2)), (r == n_runs - 1) && (i == len - 1));
            end
            else
            begin
                value = pick_value();
                if (mode == 8 && $urandom_range(1))
                    value = prev_value;      // broken split: this run merges with the previous one
                else if (r > 0 && value == prev_value)
                    value[0] = ~value[0];
                queue_run(value, len, r == n_runs - 1);
                prev_value = value;
            end
            n_items += len;
        end
    endtask

    // Sampling side: acceptance, prediction and width checks, all at the rising edge.
    always @(posedge clk)
    begin
        logic [LEN_W-1:0] want;
        took_item <= start && !busy;
        if (rst_n && start && !busy)
            predict_width(coefficient, is_last);
        if (rst_n && done)
        begin
            if (widths_due.size() == 0)
                report_mismatch($sformatf("pad_width %0d with no width expected",
                                          pad_width));
            else
            begin
                want = widths_due.pop_front();
                if (pad_width !== want)
                    report_mismatch($sformatf("pad_width %0d, expected %0d",
                                              pad_width, want));
            end
        end
    end

    // Driving side: inputs change at the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n && (!start || took_item))
        begin
            if (pending_coefs.size() == 0 ||
                $urandom_range(99) < pending_coefs[0].idle_pct)
            begin
                start       <= 1'b0;
                coefficient <= {$urandom, $urandom};
                is_last     <= 1'($urandom_range(1));
            end
            else
            begin
                start       <= 1'b1;
                coefficient <= pending_coefs[0].coef;
                is_last     <= pending_coefs[0].is_end;
                void'(pending_coefs.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int phase_pct[4];
        int made;
        int n;
        phase_pct      = '{0, 53, 0, 18};
        rst_n          = 1'b0;
        phase_idle_pct = 0;

        // Directed polynomials. The first one starts with zero, the reset value of
        // the previous coefficient, which must not be compared against.
        queue_run('0, 1, 1'b1);
        queue_run('1, 1, 1'b1);
        queue_run(64'd5, 3, 1'b1);
        queue_run(64'd1, 2, 1'b0);
        queue_run(64'd2, 2, 1'b0);
        queue_run(64'd3, 2, 1'b1);
        queue_run(64'h8000_0000_0000_0000, 3, 1'b0);
        queue_run(64'h7FFF_FFFF_FFFF_FFFF, 6, 1'b1);
        queue_run('0, 1, 1'b0);
        queue_run(64'd1, 1, 1'b1);
        // The same coefficient across two polynomials must not join their runs.
        queue_run(64'd7, 2, 1'b1);
        queue_run(64'd7, 1, 1'b1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            while (pending_coefs.size() != 0)
                @(posedge clk);
            phase_idle_pct = phase_pct[p];
            made = 0;
            while (made < RANDOM_ITEMS / 4)
            begin
                queue_polynomial(n);
                made += n;
            end
        end

        while (pending_coefs.size() != 0 || start || widths_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && widths_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
